FILE: rtl/sbf_pkg.sv
// Shared types, constants and a helper function of the stack blur filter.
`default_nettype none

package sbf_pkg;

	// Default sizing of the frame stores and register limits.
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int MAX_RADIUS_DEF = 15;

	// Fixed field widths.
	localparam int W_W        = 10;
	localparam int H_W        = 13;
	localparam int R_W        = 4;
	localparam int CH_W       = 8;
	localparam int RING_W     = 7;
	localparam int N_W        = 24;
	localparam int SUM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} cfg_reg_t;

	// Input transaction payload.
	typedef struct packed {
		logic            func;
		logic [CH_W-1:0] in_alpha;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} pix_t;

	// Output transaction payload.
	typedef struct packed {
		logic [CH_W-1:0] out_alpha;
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            frame_done;
	} res_t;

	// Active frame geometry.
	typedef struct packed {
		logic [W_W-1:0] w;
		logic [H_W-1:0] h;
		logic [R_W-1:0] r;
	} cfg_t;

	// Work command from the front end to the back end.
	typedef struct packed {
		logic              is_pix;
		logic              last_col;
		logic              do_out;
		logic              frame_done;
		logic [CH_W-1:0]   a;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [W_W-1:0]    col;
		logic [RING_W-1:0] row_ring;
		logic [W_W-1:0]    x;
		logic [H_W-1:0]    y;
		logic [RING_W-1:0] y_ring;
	} cmd_t;

	// Address width of a store, at least one bit.
	function automatic int clog2m(input int v);
		int n;
		n = $clog2(v);
		return (n < 1) ? 1 : n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sbf_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module sbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [sbf_pkg::clog2m(DEPTH)-1:0]     waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [sbf_pkg::clog2m(DEPTH)-1:0]     raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/sbf_fifo.sv
// Command queue between the front end and the back end.
`default_nettype none

module sbf_fifo #(
	parameter int DEPTH = sbf_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire sbf_pkg::cmd_t wr_cmd,
	output logic               full,
	input  wire logic          pop,
	output sbf_pkg::cmd_t      rd_cmd,
	output logic               empty
);

	localparam int PW = sbf_pkg::clog2m(DEPTH);

	sbf_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full   = (cnt_q == (PW+1)'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_cmd = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbf_div.sv
// Restoring divider of three tent sums by (radius+1)^2, one quotient bit per cycle.
`default_nettype none

module sbf_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [2:0][sbf_pkg::SUM_W-1:0]      sums,
	input  wire logic [sbf_pkg::R_W-1:0]              r,
	output logic                                      done,
	output logic      [2:0][sbf_pkg::CH_W-1:0]        quo
);

	localparam int SW = sbf_pkg::SUM_W;
	localparam int DW = SW + 1;

	logic [2:0][SW-1:0] rem_q;
	logic [DW-1:0]      dv_q;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic [4:0]         r1;
	logic [8:0]         dsq;

	assign r1  = {1'b0, r} + 5'd1;
	assign dsq = 9'(r1) * 9'(r1);

	// Quotient and remainder; sums stay below 256 times the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= sums;
			dv_q  <= DW'({dsq, 7'd0});
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				if ({1'b0, rem_q[k]} >= dv_q) begin
					rem_q[k] <= SW'({1'b0, rem_q[k]} - dv_q);
					quo[k]   <= {quo[k][sbf_pkg::CH_W-2:0], 1'b1};
				end else begin
					quo[k]   <= {quo[k][sbf_pkg::CH_W-2:0], 1'b0};
				end
			end
			dv_q <= dv_q >> 1;
		end
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbf_front.sv
// Front end: configuration registers, frame position tracking and command issue.
`default_nettype none

module sbf_front #(
	parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sbf_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_RADIUS = sbf_pkg::MAX_RADIUS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sbf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sbf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                               pix_valid,
	output logic                                    pix_ready,
	input  wire sbf_pkg::pix_t                      pix,
	output sbf_pkg::cfg_t                           cfg,
	output logic                                    push,
	output sbf_pkg::cmd_t                           cmd,
	input  wire logic                               full
);

	localparam int W_W    = sbf_pkg::W_W;
	localparam int H_W    = sbf_pkg::H_W;
	localparam int R_W    = sbf_pkg::R_W;
	localparam int N_W    = sbf_pkg::N_W;
	localparam int RING_W = sbf_pkg::RING_W;
	localparam int RING   = 2 * MAX_RADIUS + 1;

	logic [W_W-1:0]     w_q;
	logic [H_W-1:0]     h_q;
	logic [R_W-1:0]     r_q;
	logic [N_W-1:0]     n_q;
	logic [W_W-1:0]     in_col_q;
	logic [RING_W-1:0]  in_ring_q;
	logic [W_W-1:0]     x_q;
	logic [H_W-1:0]     y_q;
	logic [RING_W-1:0]  y_ring_q;

	logic [W_W+H_W-1:0] total;
	logic [14:0]        lat;
	logic               is_pix, do_out, last_col, out_last_col, done, accept;

	function automatic logic [W_W-1:0] clamp_w(input logic [W_W-1:0] v);
		if (v == '0) return W_W'(1);
		if (int'(v) > MAX_WIDTH) return W_W'(MAX_WIDTH);
		return v;
	endfunction

	function automatic logic [H_W-1:0] clamp_h(input logic [H_W-1:0] v);
		if (v == '0) return H_W'(1);
		if (int'(v) > MAX_HEIGHT) return H_W'(MAX_HEIGHT);
		return v;
	endfunction

	function automatic logic [R_W-1:0] clamp_r(input logic [R_W-1:0] v);
		if (int'(v) > MAX_RADIUS) return R_W'(MAX_RADIUS);
		return v;
	endfunction

	function automatic logic [RING_W-1:0] ring_inc(input logic [RING_W-1:0] v);
		return (v == RING_W'(RING - 1)) ? '0 : v + RING_W'(1);
	endfunction

	assign cfg = '{w: w_q, h: h_q, r: r_q};

	// Frame geometry and item classification.
	assign total        = (W_W+H_W)'(w_q) * (W_W+H_W)'(h_q);
	assign lat          = 15'(r_q) * 15'(w_q) + 15'(r_q);
	assign is_pix       = (n_q < N_W'(total));
	assign do_out       = (n_q >= N_W'(lat));
	assign last_col     = (in_col_q == w_q - W_W'(1));
	assign out_last_col = (x_q == w_q - W_W'(1));
	assign done         = do_out && out_last_col && (y_q == h_q - H_W'(1));

	// An early drain transaction is taken and dropped.
	assign pix_ready = !full;
	assign accept    = pix_valid && pix_ready;
	assign push      = accept && !(pix.func && is_pix);

	always_comb begin
		cmd.is_pix     = is_pix;
		cmd.last_col   = last_col;
		cmd.do_out     = do_out;
		cmd.frame_done = done;
		cmd.a          = pix.in_alpha;
		cmd.red        = pix.in_red;
		cmd.green      = pix.in_green;
		cmd.blue       = pix.in_blue;
		cmd.col        = in_col_q;
		cmd.row_ring   = in_ring_q;
		cmd.x          = x_q;
		cmd.y          = y_q;
		cmd.y_ring     = y_ring_q;
	end

	// Registers and frame counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= clamp_w(W_W'(512));
			h_q       <= clamp_h(H_W'(512));
			r_q       <= clamp_r(R_W'(1));
			n_q       <= '0;
			in_col_q  <= '0;
			in_ring_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
			y_ring_q  <= '0;
		end else if (cfg_we) begin
			unique case (sbf_pkg::cfg_reg_t'(cfg_index))
				sbf_pkg::REG_WIDTH:  w_q <= clamp_w(cfg_wdata[W_W-1:0]);
				sbf_pkg::REG_HEIGHT: h_q <= clamp_h(cfg_wdata[H_W-1:0]);
				sbf_pkg::REG_RADIUS: r_q <= clamp_r(cfg_wdata[R_W-1:0]);
				default: ;
			endcase
			if (cfg_index == sbf_pkg::REG_WIDTH || cfg_index == sbf_pkg::REG_HEIGHT ||
			    cfg_index == sbf_pkg::REG_RADIUS) begin
				n_q       <= '0;
				in_col_q  <= '0;
				in_ring_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
				y_ring_q  <= '0;
			end
		end else if (push) begin
			if (done) begin
				n_q       <= '0;
				in_col_q  <= '0;
				in_ring_q <= '0;
				x_q       <= '0;
				y_q       <= '0;
				y_ring_q  <= '0;
			end else begin
				n_q <= n_q + N_W'(1);
				if (is_pix) begin
					if (last_col) begin
						in_col_q  <= '0;
						in_ring_q <= ring_inc(in_ring_q);
					end else begin
						in_col_q <= in_col_q + W_W'(1);
					end
				end
				if (do_out) begin
					if (out_last_col) begin
						x_q      <= '0;
						y_q      <= y_q + H_W'(1);
						y_ring_q <= ring_inc(y_ring_q);
					end else begin
						x_q <= x_q + W_W'(1);
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sbf_back.sv
// Back end: row store, line ring, shared tent engine and output register.
`default_nettype none

module sbf_back #(
	parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = sbf_pkg::MAX_RADIUS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbf_pkg::cfg_t cfg,
	input  wire logic          empty,
	input  wire sbf_pkg::cmd_t rd_cmd,
	output logic               pop,
	output logic               res_valid,
	input  wire logic          res_ready,
	output sbf_pkg::res_t      res
);

	localparam int W_W    = sbf_pkg::W_W;
	localparam int H_W    = sbf_pkg::H_W;
	localparam int R_W    = sbf_pkg::R_W;
	localparam int CH_W   = sbf_pkg::CH_W;
	localparam int SUM_W  = sbf_pkg::SUM_W;
	localparam int RING_W = sbf_pkg::RING_W;
	localparam int RING   = 2 * MAX_RADIUS + 1;
	localparam int CAW    = sbf_pkg::clog2m(MAX_WIDTH);
	localparam int LDEPTH = RING * MAX_WIDTH;
	localparam int LAW    = sbf_pkg::clog2m(LDEPTH);
	localparam int TW     = R_W + 1;
	localparam int CW     = W_W + 2;
	localparam int YW     = H_W + 2;
	localparam int PW     = CH_W + TW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PIX, ST_HSET, ST_VSET, ST_TAP, ST_DRAIN, ST_DGO, ST_DWAIT, ST_OUT
	} state_t;

	state_t                   state_q;
	sbf_pkg::cmd_t            cmd_q;
	logic                     vert_q;
	logic [W_W-1:0]           hc_q, he_q;
	logic signed [TW-1:0]     tap_q;
	logic signed [CW-1:0]     cc_q;
	logic signed [YW-1:0]     yy_q;
	logic [RING_W-1:0]        vring_q;
	logic                     rd_v_q, rd_ctr_q;
	logic [TW-1:0]            rd_wgt_q;
	logic [2:0][SUM_W-1:0]    sum_q;
	logic [CH_W-1:0]          alpha_q;
	sbf_pkg::res_t            res_q;
	logic                     res_valid_q;

	logic [TW-1:0]            tap_abs, wgt;
	logic signed [CW-1:0]     w_last_s;
	logic signed [YW-1:0]     h_last_s;
	logic [W_W-1:0]           hcol, hs, he;
	logic                     hneed, div_done, div_start, line_we, tap_last;
	logic [31:0]              row_rdata, line_rdata, rdata;
	logic [2:0][PW-1:0]       prod;
	logic [2:0][CH_W-1:0]     quo;
	logic [RING_W:0]          vr_wrap;

	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pop       = (state_q == ST_IDLE) && !empty;

	// Tap weight r+1-|i| and clamped column of the horizontal tap.
	assign tap_abs  = tap_q[TW-1] ? TW'(-tap_q) : TW'(tap_q);
	assign wgt      = TW'({1'b0, cfg.r}) + TW'(1) - tap_abs;
	assign tap_last = (tap_q == $signed(TW'({1'b0, cfg.r})));
	assign w_last_s = $signed(CW'({2'b00, cfg.w})) - $signed(CW'(1));
	assign h_last_s = $signed(YW'({2'b00, cfg.h})) - $signed(YW'(1));
	assign hcol     = cc_q[CW-1] ? '0 :
	                  (cc_q > w_last_s) ? cfg.w - W_W'(1) : cc_q[W_W-1:0];

	// Horizontal columns finished by this pixel.
	assign hneed = (cmd_q.col >= W_W'(cfg.r)) || cmd_q.last_col;
	assign hs    = (cmd_q.col >= W_W'(cfg.r)) ? cmd_q.col - W_W'(cfg.r) : '0;
	assign he    = cmd_q.last_col ? cfg.w - W_W'(1) : cmd_q.col - W_W'(cfg.r);

	// Ring slot of the first vertical tap.
	assign vr_wrap = (RING_W+1)'({1'b0, cmd_q.y_ring}) + (RING_W+1)'(RING) -
	                 (RING_W+1)'(cfg.r);

	assign div_start = (state_q == ST_DGO);
	assign line_we   = (state_q == ST_DWAIT) && div_done && !vert_q;

	sbf_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_ram (
		.clk   (clk),
		.we    (state_q == ST_PIX),
		.waddr (CAW'(cmd_q.col)),
		.wdata ({cmd_q.a, cmd_q.red, cmd_q.green, cmd_q.blue}),
		.raddr (CAW'(hcol)),
		.rdata (row_rdata)
	);

	sbf_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (LAW'(int'(cmd_q.row_ring) * MAX_WIDTH + int'(hc_q))),
		.wdata ({alpha_q, quo[2], quo[1], quo[0]}),
		.raddr (LAW'(int'(vring_q) * MAX_WIDTH + int'(cmd_q.x))),
		.rdata (line_rdata)
	);

	sbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sums   (sum_q),
		.r      (cfg.r),
		.done   (div_done),
		.quo    (quo)
	);

	// Weighted products of the tap that came back from memory.
	assign rdata = vert_q ? line_rdata : row_rdata;
	always_comb begin
		prod[2] = PW'(rd_wgt_q) * PW'(rdata[23:16]);
		prod[1] = PW'(rd_wgt_q) * PW'(rdata[15:8]);
		prod[0] = PW'(rd_wgt_q) * PW'(rdata[7:0]);
	end

	// Sequencer, accumulators and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			rd_v_q      <= 1'b0;
		end else begin
			rd_v_q   <= (state_q == ST_TAP);
			rd_wgt_q <= wgt;
			rd_ctr_q <= (tap_q == '0);
			if (rd_v_q) begin
				for (int k = 0; k < 3; k++) begin
					sum_q[k] <= sum_q[k] + SUM_W'(prod[k]);
				end
				if (rd_ctr_q) begin
					alpha_q <= rdata[31:24];
				end
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						cmd_q <= rd_cmd;
						if (rd_cmd.is_pix) begin
							state_q <= ST_PIX;
						end else if (rd_cmd.do_out) begin
							state_q <= ST_VSET;
						end
					end
				end
				ST_PIX: begin
					hc_q <= hs;
					he_q <= he;
					if (hneed) begin
						state_q <= ST_HSET;
					end else if (cmd_q.do_out) begin
						state_q <= ST_VSET;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_HSET: begin
					cc_q    <= $signed(CW'({2'b00, hc_q})) - $signed(CW'(cfg.r));
					tap_q   <= -$signed(TW'({1'b0, cfg.r}));
					sum_q   <= '0;
					vert_q  <= 1'b0;
					state_q <= ST_TAP;
				end
				ST_VSET: begin
					yy_q <= $signed(YW'({2'b00, cmd_q.y})) - $signed(YW'(cfg.r));
					if (cmd_q.y < H_W'(cfg.r)) begin
						vring_q <= '0;
					end else if (cmd_q.y_ring >= RING_W'(cfg.r)) begin
						vring_q <= cmd_q.y_ring - RING_W'(cfg.r);
					end else begin
						vring_q <= vr_wrap[RING_W-1:0];
					end
					tap_q   <= -$signed(TW'({1'b0, cfg.r}));
					sum_q   <= '0;
					vert_q  <= 1'b1;
					state_q <= ST_TAP;
				end
				ST_TAP: begin
					tap_q <= tap_q + $signed(TW'(1));
					cc_q  <= cc_q + $signed(CW'(1));
					yy_q  <= yy_q + $signed(YW'(1));
					// The clamped row moves only while inside the frame.
					if (!yy_q[YW-1] && (yy_q < h_last_s)) begin
						vring_q <= (vring_q == RING_W'(RING - 1)) ? '0 :
						           vring_q + RING_W'(1);
					end
					if (tap_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DGO;
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (vert_q) begin
							state_q <= ST_OUT;
						end else if (hc_q == he_q) begin
							state_q <= cmd_q.do_out ? ST_VSET : ST_IDLE;
						end else begin
							hc_q    <= hc_q + W_W'(1);
							state_q <= ST_HSET;
						end
					end
				end
				ST_OUT: begin
					if (!res_valid_q) begin
						res_q.out_alpha  <= alpha_q;
						res_q.out_red    <= quo[2];
						res_q.out_green  <= quo[1];
						res_q.out_blue   <= quo[0];
						res_q.frame_done <= cmd_q.frame_done;
						res_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/stack_blur_filter.sv
// Top level of the separable stack blur filter for raster ARGB frames.
//
//   Channel  Signals                          Direction  Payload
//   pixel    pix_valid / pix_ready / pix      in         func and ARGB pixel
//   result   res_valid / res_ready / res      out        blurred ARGB, frame_done
//   config   cfg_we / cfg_index / cfg_wdata   in         width, height, radius
//
// The front end takes a transaction per cycle while the four-entry command queue has room.
// The back end runs one command at a time through a shared tent engine: each tent pass
// makes 2r+1 memory reads and then runs an eight-step divider; a pixel adds one pass per
// finished column (up to r+1 at a row end), a result one more pass and an output step.
// Reset clears the sequencer, queue and frame counters; the row and line stores are not cleared.
// A stalled result register holds the back end in its output step.
`default_nettype none

module stack_blur_filter #(
	parameter int MAX_WIDTH  = sbf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sbf_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_RADIUS = sbf_pkg::MAX_RADIUS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sbf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sbf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                               pix_valid,
	output logic                                    pix_ready,
	input  wire sbf_pkg::pix_t                      pix,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output sbf_pkg::res_t                           res
);

	sbf_pkg::cfg_t cfg;
	sbf_pkg::cmd_t wr_cmd, rd_cmd;
	logic          push, full, pop, empty;

	sbf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg       (cfg),
		.push      (push),
		.cmd       (wr_cmd),
		.full      (full)
	);

	sbf_fifo #(.DEPTH(sbf_pkg::QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.full   (full),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.empty  (empty)
	);

	sbf_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.empty     (empty),
		.rd_cmd    (rd_cmd),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

`default_nettype wire

FILE: rtl/sbf_checker.sv
// Port-level checks of the stack blur filter and their binding to the top level.
`default_nettype none

module sbf_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire sbf_pkg::res_t res
);

	// A stalled result transaction keeps its valid and payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The output step loads only an empty result register, so a taken result leaves a gap.
	a_res_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> !res_valid)
		else $error("result register reloaded without a gap");

	// The result register only empties through a transaction.
	a_res_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(res_ready))
		else $error("result dropped without a transaction");

endmodule

bind stack_blur_filter sbf_checker u_sbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
